[hdl/pqct_pkg.sv]
// Shared constants, codes and record types for the page quota container table.
package pqct_pkg;

  localparam int ENTRIES = 64;
  localparam int FANOUT = 3;
  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int CALC_W = $clog2(ENTRIES * FANOUT + FANOUT + 1);

  localparam int CMD_W = 3;
  localparam int ID_W = 6;
  localparam int PAGE_W = 21;
  localparam int STATUS_W = 2;
  localparam int CHILD_W = 7;
  localparam int CNT_W = 2;

  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_FIELDS_W = CHILD_W + ID_W + CNT_W + PAGE_W + PAGE_W + 1;

  localparam logic [PAGE_W-1:0] PAGE_MAX = PAGE_W'(1 << 20);
  localparam logic [CHILD_W-1:0] NO_ENTRY = CHILD_W'(64);

  localparam logic [CMD_W-1:0] CMD_SPLIT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHARGE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

  typedef struct packed {
    logic [PAGE_W-1:0] quota;
    logic [PAGE_W-1:0] usage;
    logic [ID_W-1:0]   parent;
    logic [CNT_W-1:0]  children;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                in_use;
    logic [PAGE_W-1:0]   page_usage;
    logic [PAGE_W-1:0]   page_quota;
    logic [CNT_W-1:0]    child_count;
    logic [ID_W-1:0]     parent_id;
    logic [CHILD_W-1:0]  child_id;
  } result_t;

  typedef struct packed {
    result_t           res;
    logic              par_we;
    entry_t            par_entry;
    logic              child_we;
    logic [ADDR_W-1:0] child_addr;
    entry_t            child_entry;
  } exec_out_t;

endpackage

[hdl/pqct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pqct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/pqct_exec.sv]
// Command evaluation: computes the result and the entry updates from one read entry.
module pqct_exec (
  input  logic [pqct_pkg::CMD_W-1:0]  cmd,
  input  logic [pqct_pkg::ID_W-1:0]   id,
  input  logic [pqct_pkg::PAGE_W-1:0] amount,
  input  pqct_pkg::entry_t            entry_raw,
  input  logic                        entry_valid,
  input  logic                        used_bit,
  input  logic [pqct_pkg::PAGE_W-1:0] root_quota,
  output pqct_pkg::exec_out_t         ex
);
  import pqct_pkg::*;

  entry_t              e;
  logic [PAGE_W-1:0]   quota_eff;
  logic [PAGE_W-1:0]   q;
  logic [PAGE_W:0]     sum_split;
  logic [PAGE_W:0]     need;
  logic [CALC_W-1:0]   child_calc;
  logic                id_ok;
  logic                split_ok;
  logic [PAGE_W-1:0]   usage_new;
  logic [CNT_W-1:0]    children_new;

  always_comb begin
    e = entry_valid ? entry_raw : '0;
    quota_eff = (id == '0) ? root_quota : e.quota;
    q = (amount > PAGE_MAX) ? PAGE_MAX : amount;
    sum_split = {1'b0, e.usage} + {1'b0, q};
    need = {1'b0, e.usage} + {1'b0, amount};
    child_calc = CALC_W'(id) * CALC_W'(FANOUT) + CALC_W'(1) + CALC_W'(e.children);
    id_ok = (32'(id) < ENTRIES);
    split_ok = (32'(e.children) < FANOUT) && (32'(child_calc) < ENTRIES);

    usage_new = e.usage;
    children_new = e.children;
    ex = '0;
    ex.res.status = ST_OK;
    ex.res.child_id = NO_ENTRY;
    ex.child_addr = child_calc[ADDR_W-1:0];
    ex.child_entry.quota = q;
    ex.child_entry.usage = '0;
    ex.child_entry.parent = id;
    ex.child_entry.children = '0;

    unique case (cmd)
      CMD_SPLIT: begin
        if (!split_ok) begin
          ex.res.status = ST_REFUSED;
        end else begin
          if (sum_split > {1'b0, PAGE_MAX}) begin
            usage_new = PAGE_MAX;
            ex.res.status = ST_SATURATED;
          end else begin
            usage_new = sum_split[PAGE_W-1:0];
          end
          children_new = e.children + CNT_W'(1);
          ex.par_we = 1'b1;
          ex.child_we = 1'b1;
          ex.res.child_id = CHILD_W'(child_calc);
        end
      end
      CMD_CHECK: begin
        ex.res.status = (need <= {1'b0, quota_eff}) ? ST_OK : ST_REFUSED;
      end
      CMD_CHARGE: begin
        ex.par_we = 1'b1;
        if (e.usage >= PAGE_MAX) begin
          usage_new = PAGE_MAX;
          ex.res.status = ST_SATURATED;
        end else begin
          usage_new = e.usage + PAGE_W'(1);
        end
      end
      CMD_RELEASE: begin
        if (e.usage == '0) begin
          ex.res.status = ST_SATURATED;
        end else begin
          usage_new = e.usage - PAGE_W'(1);
          ex.par_we = 1'b1;
        end
      end
      CMD_QUERY: begin
        ex.res.status = ST_OK;
      end
      default: begin
        ex.res.status = ST_REFUSED;
      end
    endcase

    ex.par_entry = e;
    ex.par_entry.usage = usage_new;
    ex.par_entry.children = children_new;

    ex.res.parent_id = e.parent;
    ex.res.child_count = children_new;
    ex.res.page_quota = quota_eff;
    ex.res.page_usage = usage_new;
    ex.res.in_use = used_bit;

    if (!id_ok) begin
      ex.par_we = 1'b0;
      ex.child_we = 1'b0;
      ex.res = '0;
      ex.res.status = ST_REFUSED;
      ex.res.child_id = NO_ENTRY;
    end
  end

endmodule

[hdl/page_quota_container_table_core.sv]
// Top level of the page quota container table: sequencer, table memory and result register.
// The entry is read at the transfer, and the result register loads once the output is free.
// Items pass the idle and execute states, a successful split also the child state, since
// parent and child share one write port; an item waits while the previous result is held.
// Reset is synchronous: per-entry valid bits clear the table at once (no clearing pass),
// only entry 0 is marked in use, and root_quota returns to 0.
module page_quota_container_table_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // req_id [5:0], amount [26:6], zero fill above
  input  logic [pqct_pkg::IN_DATA_W-1:0]  s_tdata,
  // cmd [2:0]
  input  logic [pqct_pkg::CMD_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // child_id [6:0], parent_id [12:7], child_count [14:13], page_quota [35:15],
  // page_usage [56:36], in_use [57], zero fill above
  output logic [pqct_pkg::OUT_DATA_W-1:0] m_tdata,
  // status [1:0]
  output logic [pqct_pkg::STATUS_W-1:0]   m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pqct_pkg::PAGE_W-1:0]     cfg_data
);
  import pqct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_CHILD = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [CMD_W-1:0]    cmd_r;
  logic [ID_W-1:0]     id_r;
  logic [PAGE_W-1:0]   amount_r;
  logic [PAGE_W-1:0]   root_quota;
  logic [ENTRIES-1:0]  valid;
  logic [ENTRIES-1:0]  used;
  logic [ADDR_W-1:0]   child_addr;
  entry_t              child_entry;
  result_t             out_res;

  logic                in_xfer;
  logic                out_free;
  logic                exec_go;
  logic [ADDR_W-1:0]   id_addr;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  entry_t              ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  entry_t              ram_rdata;
  exec_out_t           ex;

  assign s_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign exec_go = (state == S_EXEC) && out_free;
  assign id_addr = id_r[ADDR_W-1:0];

  assign ram_raddr = (state == S_IDLE) ? s_tdata[ADDR_W-1:0] : id_addr;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = id_addr;
    ram_wdata = ex.par_entry;
    if (state == S_CHILD) begin
      ram_we = 1'b1;
      ram_waddr = child_addr;
      ram_wdata = child_entry;
    end else if (exec_go) begin
      ram_we = ex.par_we;
    end
  end

  pqct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pqct_exec u_exec (
    .cmd         (cmd_r),
    .id          (id_r),
    .amount      (amount_r),
    .entry_raw   (ram_rdata),
    .entry_valid (valid[id_addr]),
    .used_bit    (used[id_addr]),
    .root_quota  (root_quota),
    .ex          (ex)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = ex.child_we ? S_CHILD : S_IDLE;
        end
      end
      S_CHILD: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      root_quota <= '0;
      valid <= '0;
      used <= ENTRIES'(1);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        root_quota <= (cfg_data > PAGE_MAX) ? PAGE_MAX : cfg_data;
      end
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      if (state == S_CHILD) begin
        used[child_addr] <= 1'b1;
      end
      if (exec_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= s_tuser;
      id_r <= s_tdata[ID_W-1:0];
      amount_r <= s_tdata[ID_W +: PAGE_W];
    end
    if (exec_go) begin
      out_res <= ex.res;
      child_addr <= ex.child_addr;
      child_entry <= ex.child_entry;
    end
  end

  assign m_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_res.in_use, out_res.page_usage,
                    out_res.page_quota, out_res.child_count, out_res.parent_id,
                    out_res.child_id};
  assign m_tuser = out_res.status;

endmodule

[hdl/pqct_checker.sv]
// Port-level checker for the page quota container table, bound to the top level.
module pqct_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pqct_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [pqct_pkg::STATUS_W-1:0]   m_tuser
);
  import pqct_pkg::*;

  // No result is left pending across a reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Items are taken one at a time, so a transfer is never directly followed by another.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in progress");

  // A refused command never reports a new child.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_REFUSED) |-> (m_tdata[CHILD_W-1:0] == NO_ENTRY))
    else $error("refused command reports a child");

  // Usage and quota never leave the page range.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[56:36] <= PAGE_MAX) && (m_tdata[35:15] <= PAGE_MAX))
    else $error("page count out of range");

endmodule

bind page_quota_container_table_core pqct_checker u_pqct_checker (.*);
